// ===== hw/rtl/kbsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsc_pkg: shared definitions for the keyed byte stream cipher
// Operation codes, field widths, default key length and sequencer states.
// ----------------------------------------------------------------------------
package kbsc_pkg;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned OP_W        = 3;
    localparam int unsigned KEY_LEN_DEF = 64;
    localparam int unsigned TAB_DEPTH   = 256;

    localparam logic [OP_W-1:0] OP_LOAD_KEY = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_TAB = 3'd1;
    localparam logic [OP_W-1:0] OP_ENCRYPT  = 3'd2;
    localparam logic [OP_W-1:0] OP_DECRYPT  = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTART  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC,
        ST_CHAIN,
        ST_DEC_R,
        ST_DEC,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/keyed_byte_stream_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_byte_stream_cipher: chained keyed byte cipher, memory-based sequencer
// Key store, forward table and inverse table sit in synchronous-read memories
// with registered read data; a small sequencer walks the rounds of one byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready, s_op/s_index/s_value) carries one command
//   per beat: load key byte, load table entry, encrypt, decrypt or restart.
//   Every accepted beat yields exactly one result beat on m_valid/m_ready
//   with m_data_out (the transformed byte, zero for loads, restart and unused codes).
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes the chain seed; it
//   is always ready and is meant to be written while the block is idle.
// Sequence, r = 1..4 rounds (from accept to result registered):
//   loads, restart, unused codes : straight to the result slot
//   encrypt : one fwd/key read per round, then the chain read
//   decrypt : round count read, then one inv read per round
//   One item is in work at a time; the loop through the table memory's read
//   latency sets the round rate. A new beat is taken while a finished result
//   still waits on m_valid; only the next completion waits for the drain.
// Reset: positions and chains clear to zero, seed clears to zero, output
//   goes idle. Key and table memories are not cleared; load before use.
// Stall: a held result keeps m_data_out steady until m_ready is seen.
// ----------------------------------------------------------------------------
module keyed_byte_stream_cipher
    import kbsc_pkg::*;
#(
    parameter int unsigned KEY_LEN = KEY_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [DATA_W-1:0] s_index,
    input  logic [DATA_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_data_out,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DATA_W-1:0] cfg_data
);

    localparam int unsigned POS_W = $clog2(KEY_LEN);
    localparam logic [POS_W:0]   KEY_LEN_S = (POS_W+1)'(KEY_LEN);
    localparam logic [POS_W-1:0] KEY_LAST  = POS_W'(KEY_LEN - 1);
    localparam logic [DATA_W:0]  KEY_LEN_I = (DATA_W+1)'(KEY_LEN);

    // Memories
    logic [DATA_W-1:0] key_mem [KEY_LEN];
    logic [DATA_W-1:0] fwd_mem [TAB_DEPTH];
    logic [DATA_W-1:0] inv_mem [TAB_DEPTH];

    logic [DATA_W-1:0] key_q, fwd_q, inv_q;
    logic [POS_W-1:0]  key_raddr;
    logic [DATA_W-1:0] fwd_raddr, inv_raddr;
    logic              key_we, tab_we;

    // Registers
    state_t            state_reg, state_next;
    logic [POS_W-1:0]  enc_pos_reg, enc_pos_next;
    logic [POS_W-1:0]  dec_pos_reg, dec_pos_next;
    logic [DATA_W-1:0] enc_chain_reg, enc_chain_next;
    logic [DATA_W-1:0] dec_chain_reg, dec_chain_next;
    logic [DATA_W-1:0] seed_reg;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] ctmp_reg, ctmp_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [2:0]        rem_reg, rem_next;
    logic [2:0]        rnd_reg, rnd_next;
    logic [POS_W-1:0]  kidx_reg, kidx_next;
    logic              first_reg, first_next;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;

    logic              accept, out_free;
    logic [2:0]        enc_r, dec_r, enc_rem;
    logic [DATA_W-1:0] enc_b, enc_out, dec_opnd;
    logic [POS_W-1:0]  kidx_inc, kidx_dec, dec_k0;

    function automatic logic [POS_W-1:0] pos_wrap(input logic [POS_W:0] s);
        logic [POS_W:0] t;
        t = s;
        if (s >= KEY_LEN_S) begin
            t = s - KEY_LEN_S;
        end
        return t[POS_W-1:0];
    endfunction

    function automatic logic [2:0] round_cnt(input logic [DATA_W-1:0] k,
                                             input logic [DATA_W-1:0] h);
        logic [DATA_W-1:0] x;
        x = k ^ h;
        return {1'b0, x[1:0]} + 3'd1;
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data_out = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Round arithmetic
    assign enc_r    = round_cnt(key_q, enc_chain_reg);
    assign dec_r    = round_cnt(key_q, dec_chain_reg);
    assign enc_rem  = first_reg ? enc_r : rem_reg;
    assign enc_b    = fwd_q ^ key_q;
    assign enc_out  = enc_b ^ enc_chain_reg;
    assign dec_opnd = (first_reg ? (val_reg ^ dec_chain_reg) : inv_q) ^ key_q;
    assign kidx_inc = (kidx_reg == KEY_LAST) ? '0 : kidx_reg + POS_W'(1);
    assign kidx_dec = (kidx_reg == '0) ? KEY_LAST : kidx_reg - POS_W'(1);
    assign dec_k0   = pos_wrap({1'b0, dec_pos_reg} + (POS_W+1)'(dec_r - 3'd1));

    // Load writes
    assign key_we = accept && (s_op == OP_LOAD_KEY) && ({1'b0, s_index} < KEY_LEN_I);
    assign tab_we = accept && (s_op == OP_LOAD_TAB);

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[s_index[POS_W-1:0]] <= s_value;
        end
        key_q <= key_mem[key_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            fwd_mem[s_index] <= s_value;
        end
        fwd_q <= fwd_mem[fwd_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            inv_mem[s_value] <= s_index;
        end
        inv_q <= inv_mem[inv_raddr];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_ENCRYPT) begin
                        state_next = ST_ENC;
                    end else if (s_op == OP_DECRYPT) begin
                        state_next = ST_DEC_R;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ENC: begin
                if (enc_rem == 3'd1) begin
                    state_next = ST_CHAIN;
                end
            end
            ST_CHAIN: state_next = ST_DONE;
            ST_DEC_R: state_next = ST_DEC;
            ST_DEC: begin
                if (rem_reg == 3'd0 && !first_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory addressing
    always_comb begin
        enc_pos_next   = enc_pos_reg;
        dec_pos_next   = dec_pos_reg;
        enc_chain_next = enc_chain_reg;
        dec_chain_next = dec_chain_reg;
        val_next       = val_reg;
        ctmp_next      = ctmp_reg;
        res_next       = res_reg;
        rem_next       = rem_reg;
        rnd_next       = rnd_reg;
        kidx_next      = kidx_reg;
        first_next     = first_reg;
        key_raddr      = kidx_reg;
        fwd_raddr      = val_reg;
        inv_raddr      = s_value;
        unique case (state_reg)
            ST_IDLE: begin
                // Issue the first reads straight from the input beat
                key_raddr  = (s_op == OP_DECRYPT) ? dec_pos_reg : enc_pos_reg;
                fwd_raddr  = s_value;
                inv_raddr  = s_value;
                kidx_next  = enc_pos_reg;
                val_next   = s_value;
                first_next = 1'b1;
                res_next   = '0;
                if (accept && s_op == OP_RESTART) begin
                    enc_pos_next   = '0;
                    dec_pos_next   = '0;
                    enc_chain_next = seed_reg;
                    dec_chain_next = seed_reg;
                end
            end
            ST_ENC: begin
                first_next = 1'b0;
                if (first_reg) begin
                    rnd_next = enc_r;
                end
                key_raddr = kidx_inc;
                fwd_raddr = enc_b;
                inv_raddr = enc_out;
                if (enc_rem == 3'd1) begin
                    res_next = enc_out;
                end else begin
                    rem_next  = enc_rem - 3'd1;
                    kidx_next = kidx_inc;
                end
            end
            ST_CHAIN: begin
                enc_chain_next = res_reg ^ inv_q;
                enc_pos_next   = pos_wrap({1'b0, enc_pos_reg} + (POS_W+1)'(rnd_reg));
            end
            ST_DEC_R: begin
                // Round count known: start the key walk from its far end
                rnd_next   = dec_r;
                rem_next   = dec_r;
                ctmp_next  = val_reg ^ inv_q;
                kidx_next  = dec_k0;
                key_raddr  = dec_k0;
                first_next = 1'b1;
            end
            ST_DEC: begin
                key_raddr = kidx_dec;
                inv_raddr = dec_opnd;
                if (rem_reg == 3'd0 && !first_reg) begin
                    res_next       = inv_q;
                    dec_chain_next = ctmp_reg;
                    dec_pos_next   = pos_wrap({1'b0, dec_pos_reg} + (POS_W+1)'(rnd_reg));
                end else begin
                    rem_next   = rem_reg - 3'd1;
                    kidx_next  = kidx_dec;
                    first_next = 1'b0;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            enc_pos_reg   <= '0;
            dec_pos_reg   <= '0;
            enc_chain_reg <= '0;
            dec_chain_reg <= '0;
            seed_reg      <= '0;
            m_valid_reg   <= 1'b0;
            rem_reg       <= '0;
            rnd_reg       <= '0;
            kidx_reg      <= '0;
            first_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            enc_pos_reg   <= enc_pos_next;
            dec_pos_reg   <= dec_pos_next;
            enc_chain_reg <= enc_chain_next;
            dec_chain_reg <= dec_chain_next;
            rem_reg       <= rem_next;
            rnd_reg       <= rnd_next;
            kidx_reg      <= kidx_next;
            first_reg     <= first_next;
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_data;
            end
            // Hold the result until drained; refill when the slot frees
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        ctmp_reg <= ctmp_next;
        res_reg  <= res_next;
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    // Assertions
    a_enc_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, enc_pos_reg} < KEY_LEN_S)
        else $error("encrypt position out of range");

    a_dec_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, dec_pos_reg} < KEY_LEN_S)
        else $error("decrypt position out of range");

    a_kidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENC || state_reg == ST_DEC) |-> ({1'b0, kidx_reg} < KEY_LEN_S))
        else $error("key walk index out of range");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEC) |-> (rem_reg <= 3'd4))
        else $error("round count out of range");

    a_done_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("finished result not delivered");

endmodule

// ===== sim/keyed_byte_stream_cipher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_byte_stream_cipher_checker: result predictor and scoreboard
// Watches the command, result and seed channels. Keeps its own copy of the
// key, the substitution tables, the positions and the chains, predicts one
// output byte per accepted command and compares results in order.
// ----------------------------------------------------------------------------
module keyed_byte_stream_cipher_checker
    import kbsc_pkg::*;
#(
    parameter int unsigned KEY_LEN = KEY_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [DATA_W-1:0] s_index,
    input  logic [DATA_W-1:0] s_value,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [DATA_W-1:0] m_data_out,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic              end_check,
    output int unsigned       fail_count
);

    logic [DATA_W-1:0] key_mem [KEY_LEN];
    logic [DATA_W-1:0] fwd_mem [TAB_DEPTH];
    logic [DATA_W-1:0] inv_mem [TAB_DEPTH];

    int unsigned       enc_pos;
    int unsigned       dec_pos;
    logic [DATA_W-1:0] enc_chain;
    logic [DATA_W-1:0] dec_chain;
    logic [DATA_W-1:0] seed;

    logic [DATA_W-1:0] expected_bytes [$];
    int unsigned       mismatches = 0;
    int unsigned       result_no = 0;
    bit                leftovers_checked = 1'b0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        $display("[%0t] cipher check: %s", $time, what);
        mismatches++;
    endtask

    function automatic int unsigned round_count(input int unsigned pos,
                                                input logic [DATA_W-1:0] chain);
        logic [DATA_W-1:0] mix;
        mix = key_mem[pos % KEY_LEN] ^ chain;
        return int'(mix[1:0]) + 1;
    endfunction

    // Advance the cipher state by one command and return its output byte.
    function automatic logic [DATA_W-1:0] cipher_step(input logic [OP_W-1:0]   op,
                                                      input logic [DATA_W-1:0] idx,
                                                      input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] res;
        int unsigned       rounds;
        res = '0;
        case (op)
            OP_LOAD_KEY: begin
                if (idx < KEY_LEN) key_mem[idx] = val;
            end
            OP_LOAD_TAB: begin
                fwd_mem[idx] = val;
                inv_mem[val] = idx;
            end
            OP_ENCRYPT: begin
                rounds = round_count(enc_pos, enc_chain);
                b = val;
                for (int i = 0; i < rounds; i++)
                    b = fwd_mem[b] ^ key_mem[(enc_pos + i) % KEY_LEN];
                res = b ^ enc_chain;
                enc_chain = res ^ inv_mem[res];
                enc_pos = (enc_pos + rounds) % KEY_LEN;
            end
            OP_DECRYPT: begin
                rounds = round_count(dec_pos, dec_chain);
                b = val ^ dec_chain;
                for (int i = 0; i < rounds; i++)
                    b = inv_mem[b ^ key_mem[(dec_pos + rounds - 1 - i) % KEY_LEN]];
                res = b;
                dec_chain = val ^ inv_mem[val];
                dec_pos = (dec_pos + rounds) % KEY_LEN;
            end
            OP_RESTART: begin
                enc_pos = 0;
                dec_pos = 0;
                enc_chain = seed;
                dec_chain = seed;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        logic [DATA_W-1:0] want;
        if (!aresetn) begin
            enc_pos = 0;
            dec_pos = 0;
            enc_chain = '0;
            dec_chain = '0;
            seed = '0;
            expected_bytes.delete();
        end else begin
            // Retire results before queuing new work: a command's own result
            // can never come back on the edge that accepts it.
            if (m_valid && m_ready) begin
                result_no++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("result %0d: 0x%02h with nothing pending",
                                              result_no, m_data_out));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_data_out !== want)
                        report_mismatch($sformatf("result %0d: data_out 0x%02h, want 0x%02h",
                                                  result_no, m_data_out, want));
                end
            end
            if (cfg_valid && cfg_ready) seed = cfg_data;
            if (s_valid && s_ready)
                expected_bytes.push_back(cipher_step(s_op, s_index, s_value));
            if (end_check && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (expected_bytes.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              expected_bytes.size()));
            end
        end
    end

endmodule

// ===== sim/keyed_byte_stream_cipher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_byte_stream_cipher_tb: top of the cipher simulation
// Loads a full key and a permutation table, runs a short directed set of
// edge cases, then random command chunks under several chain seeds, with
// random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module keyed_byte_stream_cipher_tb;
    import kbsc_pkg::*;

    localparam int unsigned     KEY_LEN       = KEY_LEN_DEF;
    localparam int unsigned     GAP_MAX       = 18;
    localparam int unsigned     RANDOM_ITEMS  = 180;
    localparam int unsigned     CHUNKS        = 5;
    localparam int unsigned     SETTLE_CYCLES = 16;
    localparam int unsigned     LIMIT_CYCLES  = 400000;
    // Codes above restart have no function; the block must answer them with zero.
    localparam logic [OP_W-1:0] OP_SPARE_LO   = OP_RESTART + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI   = '1;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_op = '0;
    logic [DATA_W-1:0] s_index = '0;
    logic [DATA_W-1:0] s_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_data_out;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [DATA_W-1:0] cfg_data = '0;
    logic              end_check = 1'b0;
    int unsigned       fail_count;

    // Shared by both sides: when set, neither side inserts gaps or stalls.
    bit                quiet = 1'b0;

    // Beat bookkeeping used only for draining and for replaying ciphertext.
    int unsigned       beats_in = 0;
    int unsigned       beats_out = 0;
    logic [OP_W-1:0]   pending_ops [$];
    logic [DATA_W-1:0] cipher_bytes [$];
    int unsigned       cycles = 0;

    keyed_byte_stream_cipher #(
        .KEY_LEN (KEY_LEN)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_index    (s_index),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    keyed_byte_stream_cipher_checker #(
        .KEY_LEN (KEY_LEN)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_index    (s_index),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .end_check  (end_check),
        .fail_count (fail_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop: count edges and fail the run if it never finishes.
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Count beats on both channels; keep encrypt results so decrypts can
    // replay them.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beats_out <= beats_out + 1;
                if (pending_ops.size() != 0 && pending_ops.pop_front() == OP_ENCRYPT)
                    cipher_bytes.push_back(m_data_out);
            end
            if (s_valid && s_ready) begin
                beats_in <= beats_in + 1;
                pending_ops.push_back(s_op);
            end
        end
    end

    // Result side: draw a stall per beat, then hold ready until a beat moves.
    initial begin
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(GAP_MAX, 0);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic logic [DATA_W-1:0] rand_byte();
        return DATA_W'($urandom_range(255, 0));
    endfunction

    // Drive one command beat. Keep valid high across back-to-back beats;
    // drop it only when a gap is drawn.
    task automatic send_beat(input logic [OP_W-1:0]   op,
                             input logic [DATA_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(GAP_MAX, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_index <= idx;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_input();
        s_valid <= 1'b0;
    endtask

    // Wait until every accepted command has returned its result.
    task automatic wait_drained();
        do @(posedge aclk); while (beats_in != beats_out);
    endtask

    // Seed writes happen only with the block idle.
    task automatic write_seed(input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Restart, encrypt a short message, then decrypt the returned ciphertext
    // with the decrypt side still aligned to the same restart.
    task automatic round_trip(output int unsigned issued);
        int unsigned len;
        int unsigned base;
        len = $urandom_range(8, 1);
        send_beat(OP_RESTART, rand_byte(), rand_byte());
        repeat (len) send_beat(OP_ENCRYPT, rand_byte(), rand_byte());
        stop_input();
        wait_drained();
        base = cipher_bytes.size() - len;
        for (int i = 0; i < len; i++)
            send_beat(OP_DECRYPT, rand_byte(), cipher_bytes[base + i]);
        cipher_bytes.delete();
        issued = 2 * len + 1;
    endtask

    // Mostly well-formed traffic; some key and table rewrites, restarts and
    // dead codes as noise. Dead codes and out-of-range key writes do not count.
    task automatic random_chunk(input int unsigned target);
        int unsigned done;
        int unsigned pick;
        int unsigned issued;
        logic [DATA_W-1:0] idx;
        done = 0;
        while (done < target) begin
            if ($urandom_range(5, 0) == 0) quiet = !quiet;
            pick = $urandom_range(99, 0);
            if (pick < 45) begin
                round_trip(issued);
                done += issued;
            end else if (pick < 80) begin
                send_beat(($urandom_range(1, 0) != 0) ? OP_ENCRYPT : OP_DECRYPT,
                          rand_byte(), rand_byte());
                done++;
            end else if (pick < 88) begin
                idx = ($urandom_range(1, 0) != 0) ? DATA_W'($urandom_range(KEY_LEN - 1, 0))
                                                  : rand_byte();
                send_beat(OP_LOAD_KEY, idx, rand_byte());
                if (idx < KEY_LEN) done++;
            end else if (pick < 91) begin
                send_beat(OP_LOAD_TAB, rand_byte(), rand_byte());
                done++;
            end else if (pick < 95) begin
                send_beat(OP_RESTART, rand_byte(), rand_byte());
                done++;
            end else begin
                send_beat(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)),
                          rand_byte(), rand_byte());
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        int unsigned       perm [TAB_DEPTH];
        int unsigned       j;
        int unsigned       tmp;
        logic [DATA_W-1:0] seeds [CHUNKS];

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Start from the top seed so the first restart loads all ones.
        write_seed(8'hFF);

        // Fill the whole key and a full permutation before any transform,
        // so no transform ever reads an unwritten entry.
        for (int i = 0; i < KEY_LEN; i++)
            send_beat(OP_LOAD_KEY, DATA_W'(i), rand_byte());
        for (int i = 0; i < TAB_DEPTH; i++) perm[i] = i;
        for (int i = TAB_DEPTH - 1; i > 0; i--) begin
            j = $urandom_range(i, 0);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < TAB_DEPTH; i++)
            send_beat(OP_LOAD_TAB, DATA_W'(i), DATA_W'(perm[i]));

        // Directed edge cases: byte extremes, key edge positions, ignored key
        // writes past the end, a table that stops being a permutation, and
        // the dead op codes.
        send_beat(OP_RESTART, 8'h00, 8'h00);
        send_beat(OP_ENCRYPT, 8'h00, 8'h00);
        send_beat(OP_ENCRYPT, 8'hFF, 8'hFF);
        send_beat(OP_DECRYPT, 8'h00, 8'h00);
        send_beat(OP_DECRYPT, 8'hFF, 8'hFF);
        send_beat(OP_LOAD_KEY, DATA_W'(KEY_LEN - 1), 8'hFF);
        send_beat(OP_LOAD_KEY, 8'h00, 8'h00);
        send_beat(OP_LOAD_KEY, DATA_W'(KEY_LEN), 8'hAA);
        send_beat(OP_LOAD_KEY, 8'hFF, 8'h55);
        send_beat(OP_LOAD_TAB, 8'h00, 8'hFF);
        send_beat(OP_LOAD_TAB, 8'hFF, 8'h00);
        send_beat(OP_SPARE_LO, 8'hFF, 8'hFF);
        send_beat(OP_SPARE_LO + 3'd1, 8'h00, 8'h00);
        send_beat(OP_SPARE_HI, 8'hA5, 8'h5A);
        send_beat(OP_RESTART, 8'hFF, 8'hFF);
        send_beat(OP_ENCRYPT, 8'h12, 8'h80);
        send_beat(OP_ENCRYPT, 8'h34, 8'h01);
        send_beat(OP_DECRYPT, 8'h56, 8'h80);
        send_beat(OP_DECRYPT, 8'h78, 8'h7F);
        stop_input();
        wait_drained();

        // Random chunks, each under its own seed; write the seed only once
        // the previous chunk has fully drained.
        seeds[0] = 8'h00;
        seeds[1] = 8'hFF;
        seeds[2] = 8'h80;
        for (int i = 3; i < CHUNKS; i++) seeds[i] = rand_byte();
        for (int i = 0; i < CHUNKS; i++) begin
            write_seed(seeds[i]);
            random_chunk(RANDOM_ITEMS / CHUNKS);
            stop_input();
            wait_drained();
        end

        // Let any stray result show up, then close the scoreboard.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        end_check <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/kbsc_pkg.sv
hw/rtl/keyed_byte_stream_cipher.sv
sim/keyed_byte_stream_cipher_checker.sv
sim/keyed_byte_stream_cipher_tb.sv
